@@ src/i2cmwe_pkg.sv @@
package i2cmwe_pkg;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_WAIT = 4'd1,
    PH_START_T2   = 4'd2,
    PH_START_SDA  = 4'd3,
    PH_START_SCL  = 4'd4,
    PH_BIT_LOW    = 4'd5,
    PH_BIT_RISE   = 4'd6,
    PH_BIT_HIGH   = 4'd7,
    PH_AFTER_ACK  = 4'd8,
    PH_NEXT_WAIT  = 4'd9,
    PH_STOP_RISE  = 4'd10,
    PH_STOP_HIGH  = 4'd11,
    PH_STOP_END   = 4'd12
  } phase_t;

  // configuration register indexes
  localparam logic [7:0] CFG_LOW_HOLD  = 8'd0;
  localparam logic [7:0] CFG_HIGH_HOLD = 8'd1;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [15:0] LOW_HOLD_RESET  = 16'd5;
  localparam logic [15:0] HIGH_HOLD_RESET = 16'd4;

  // bit index of the clock in a byte that carries the ack
  localparam logic [3:0] BIT_ACK = 4'd8;
  localparam logic [7:0] SHIFT_RELEASED = 8'hFF;

  // tick queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  // one time tick of line samples and offered byte
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       byte_offered;
    logic [7:0] byte_value;
    logic       byte_is_last;
  } tick_t;

  // bus drive and status after one tick
  typedef struct packed {
    logic scl_pull_low;
    logic sda_pull_low;
    logic byte_accepted;
    logic bus_busy;
    logic message_done;
    logic message_nacked;
  } result_t;

  // queue head as seen by the back part
  typedef struct packed {
    logic  valid;
    tick_t item;
  } q_head_t;

endpackage

@@ src/i2cmwe_tick_if.sv @@
interface i2cmwe_tick_if;
  logic               valid;
  logic               ready;
  i2cmwe_pkg::tick_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/i2cmwe_result_if.sv @@
interface i2cmwe_result_if;
  logic                valid;
  logic                ready;
  i2cmwe_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/i2cmwe_cfg_if.sv @@
interface i2cmwe_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [i2cmwe_pkg::CFG_INDEX_W-1:0]   index;
  logic [i2cmwe_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/i2cmwe_front.sv @@
module i2cmwe_front (
  input  logic                clk,
  input  logic                rst,
  i2cmwe_tick_if.sink         ticks,
  input  logic                pop,
  output i2cmwe_pkg::q_head_t head
);

  i2cmwe_pkg::tick_t                entries [i2cmwe_pkg::Q_DEPTH];
  logic [i2cmwe_pkg::Q_AW-1:0]      wr_ptr;
  logic [i2cmwe_pkg::Q_AW-1:0]      rd_ptr;
  logic [i2cmwe_pkg::Q_AW:0]        count;
  logic                             push;
  logic                             do_pop;

  // accept a word while there is room
  assign ticks.ready = (count != (i2cmwe_pkg::Q_AW+1)'(i2cmwe_pkg::Q_DEPTH));
  assign push        = ticks.valid && ticks.ready;
  assign do_pop      = pop && head.valid;

  // head of queue
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= ticks.data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + (i2cmwe_pkg::Q_AW+1)'(1);
        2'b01:   count <= count - (i2cmwe_pkg::Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/i2cmwe_back.sv @@
module i2cmwe_back #(
  parameter int unsigned HOLD_COUNTER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  i2cmwe_cfg_if.sink          cfg,
  input  i2cmwe_pkg::q_head_t head,
  output logic                pop,
  i2cmwe_result_if.source     results
);

  localparam int unsigned W = HOLD_COUNTER_WIDTH;

  i2cmwe_pkg::phase_t  phase, phase_next;
  logic [W-1:0]        hold_cnt, hold_cnt_next;
  logic [7:0]          shreg, shreg_next;
  logic [3:0]          bit_idx, bit_idx_next;
  logic                final_flag, final_flag_next;
  logic                nack_flag, nack_flag_next;
  logic [15:0]         low_hold, high_hold;
  logic [W-1:0]        low_load, high_load;
  logic                hold_end;
  logic [W-1:0]        hold_dec;
  logic                step;
  logic                res_valid;
  i2cmwe_pkg::result_t res_data, res_next;
  i2cmwe_pkg::tick_t   t;

  // configuration writes, taken at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_hold  <= i2cmwe_pkg::LOW_HOLD_RESET;
      high_hold <= i2cmwe_pkg::HIGH_HOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        i2cmwe_pkg::CFG_LOW_HOLD:  low_hold  <= cfg.data;
        i2cmwe_pkg::CFG_HIGH_HOLD: high_hold <= cfg.data;
        default: ;
      endcase
    end
  end

  // hold loads saturate to the counter range
  assign low_load  = (|(32'(low_hold) >> W))  ? '1 : W'(low_hold);
  assign high_load = (|(32'(high_hold) >> W)) ? '1 : W'(high_hold);

  assign hold_end = (hold_cnt <= W'(1));
  assign hold_dec = hold_cnt - W'(1);

  // step the sequencer when a queued word is present and the output register can take a word
  assign t    = head.item;
  assign step = head.valid && (!res_valid || results.ready);
  assign pop  = step;

  // next state and bus drive
  always_comb begin
    phase_next      = phase;
    hold_cnt_next   = hold_cnt;
    shreg_next      = shreg;
    bit_idx_next    = bit_idx;
    final_flag_next = final_flag;
    nack_flag_next  = nack_flag;
    res_next        = '0;

    unique case (phase)
      i2cmwe_pkg::PH_IDLE: begin
        if (t.byte_offered) begin
          res_next.byte_accepted = 1'b1;
          shreg_next      = t.byte_value;
          final_flag_next = t.byte_is_last;
          bit_idx_next    = '0;
          nack_flag_next  = 1'b0;
          phase_next      = i2cmwe_pkg::PH_START_WAIT;
        end
      end
      i2cmwe_pkg::PH_START_WAIT: begin
        if (t.scl_level) begin
          hold_cnt_next = low_load;
          phase_next    = i2cmwe_pkg::PH_START_T2;
        end
      end
      i2cmwe_pkg::PH_START_T2: begin
        if (hold_end) begin
          hold_cnt_next = high_load;
          phase_next    = i2cmwe_pkg::PH_START_SDA;
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      i2cmwe_pkg::PH_START_SDA: begin
        if (hold_end) begin
          hold_cnt_next = high_load;
          phase_next    = i2cmwe_pkg::PH_START_SCL;
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      i2cmwe_pkg::PH_START_SCL: begin
        if (hold_end) begin
          hold_cnt_next = low_load;
          phase_next    = i2cmwe_pkg::PH_BIT_LOW;
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      i2cmwe_pkg::PH_BIT_LOW: begin
        if (hold_end) begin
          phase_next = i2cmwe_pkg::PH_BIT_RISE;
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      i2cmwe_pkg::PH_BIT_RISE: begin
        // wait out clock stretching, sample ack on the ack clock (bit index BIT_ACK)
        if (t.scl_level) begin
          if (bit_idx >= i2cmwe_pkg::BIT_ACK) begin
            nack_flag_next = t.sda_level;
          end
          hold_cnt_next = high_load;
          phase_next    = i2cmwe_pkg::PH_BIT_HIGH;
        end
      end
      i2cmwe_pkg::PH_BIT_HIGH: begin
        if (hold_end) begin
          shreg_next    = {shreg[6:0], 1'b1};
          hold_cnt_next = low_load;
          if (bit_idx >= i2cmwe_pkg::BIT_ACK) begin
            phase_next = i2cmwe_pkg::PH_AFTER_ACK;
          end else begin
            bit_idx_next = bit_idx + 4'd1;
            phase_next   = i2cmwe_pkg::PH_BIT_LOW;
          end
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      i2cmwe_pkg::PH_AFTER_ACK: begin
        if (hold_end) begin
          shreg_next = i2cmwe_pkg::SHIFT_RELEASED;
          phase_next = (nack_flag || final_flag) ? i2cmwe_pkg::PH_STOP_RISE
                                                 : i2cmwe_pkg::PH_NEXT_WAIT;
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      i2cmwe_pkg::PH_NEXT_WAIT: begin
        if (t.byte_offered) begin
          res_next.byte_accepted = 1'b1;
          shreg_next      = t.byte_value;
          final_flag_next = t.byte_is_last;
          bit_idx_next    = '0;
          hold_cnt_next   = low_load;
          phase_next      = i2cmwe_pkg::PH_BIT_LOW;
        end
      end
      i2cmwe_pkg::PH_STOP_RISE: begin
        if (t.scl_level) begin
          hold_cnt_next = high_load;
          phase_next    = i2cmwe_pkg::PH_STOP_HIGH;
        end
      end
      i2cmwe_pkg::PH_STOP_HIGH: begin
        if (hold_end) begin
          hold_cnt_next = low_load;
          phase_next    = i2cmwe_pkg::PH_STOP_END;
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      i2cmwe_pkg::PH_STOP_END: begin
        if (hold_end) begin
          res_next.message_done   = 1'b1;
          res_next.message_nacked = nack_flag;
          hold_cnt_next           = '0;
          phase_next              = i2cmwe_pkg::PH_IDLE;
        end else begin
          hold_cnt_next = hold_dec;
        end
      end
      default: begin
        phase_next = i2cmwe_pkg::PH_IDLE;
      end
    endcase

    // line drive from the phase after this tick
    unique case (phase_next)
      i2cmwe_pkg::PH_START_SDA: begin
        res_next.scl_pull_low = 1'b0;
        res_next.sda_pull_low = 1'b1;
      end
      i2cmwe_pkg::PH_START_SCL: begin
        res_next.scl_pull_low = 1'b1;
        res_next.sda_pull_low = 1'b1;
      end
      i2cmwe_pkg::PH_BIT_LOW: begin
        res_next.scl_pull_low = 1'b1;
        res_next.sda_pull_low = ~shreg_next[7];
      end
      i2cmwe_pkg::PH_BIT_RISE, i2cmwe_pkg::PH_BIT_HIGH: begin
        res_next.scl_pull_low = 1'b0;
        res_next.sda_pull_low = ~shreg_next[7];
      end
      i2cmwe_pkg::PH_AFTER_ACK, i2cmwe_pkg::PH_NEXT_WAIT: begin
        res_next.scl_pull_low = 1'b1;
        res_next.sda_pull_low = 1'b0;
      end
      i2cmwe_pkg::PH_STOP_RISE, i2cmwe_pkg::PH_STOP_HIGH: begin
        res_next.scl_pull_low = 1'b0;
        res_next.sda_pull_low = 1'b1;
      end
      default: begin
        res_next.scl_pull_low = 1'b0;
        res_next.sda_pull_low = 1'b0;
      end
    endcase

    res_next.bus_busy = (phase_next != i2cmwe_pkg::PH_IDLE);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cmwe_pkg::PH_IDLE;
      hold_cnt   <= '0;
      shreg      <= i2cmwe_pkg::SHIFT_RELEASED;
      bit_idx    <= '0;
      final_flag <= 1'b0;
      nack_flag  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      hold_cnt   <= hold_cnt_next;
      shreg      <= shreg_next;
      bit_idx    <= bit_idx_next;
      final_flag <= final_flag_next;
      nack_flag  <= nack_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= res_next;
    end
  end

  assign results.valid = res_valid;
  assign results.data  = res_data;

endmodule

@@ src/i2c_master_write_engine_top.sv @@
// a tick word accepted into the queue is stepped once it is at the head and the output
// register can take a word; the step loads its result word into the output register
// throughput: one tick word per cycle while results are taken, one sequencer step per word
// reset (rst, synchronous, active high): queue and output register empty,
// sequencer idle with lines released, hold registers back to 5 and 4 ticks
module i2c_master_write_engine_top #(
  parameter int unsigned HOLD_COUNTER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  i2cmwe_tick_if.sink      ticks,
  i2cmwe_cfg_if.sink       cfg,
  i2cmwe_result_if.source  results
);

  i2cmwe_pkg::q_head_t head;
  logic                pop;

  // front: accept tick words into a short queue
  i2cmwe_front u_front (
    .clk   (clk),
    .rst   (rst),
    .ticks (ticks),
    .pop   (pop),
    .head  (head)
  );

  // back: bus sequencer and output register
  i2cmwe_back #(
    .HOLD_COUNTER_WIDTH (HOLD_COUNTER_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

`ifndef SYNTHESIS
  // a finished stop leaves the bus free and both lines released
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.message_done |->
      !results.data.bus_busy && !results.data.scl_pull_low &&
      !results.data.sda_pull_low)
    else $error("done without released idle bus");

  // nack is reported only with done
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.message_nacked |-> results.data.message_done)
    else $error("nacked without done");

  // a taken byte always starts or continues a message
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.byte_accepted |->
      results.data.bus_busy && !results.data.message_done)
    else $error("byte taken while bus not busy");

  // sequencer steps only on a queued word
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("sequencer stepped on empty queue");
`endif

endmodule
